FILE: rtl/ranging_result_averager_defines.svh
// ----------------------------------------------------------------------------
// Ranging result averager assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RANGING_RESULT_AVERAGER_DEFINES_SVH
`define RANGING_RESULT_AVERAGER_DEFINES_SVH

// Same-cycle implication, sampled on clock and quiet during reset.
`define RRA_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ranging_result_averager check failed");

// Next-cycle implication, sampled on clock and quiet during reset.
`define RRA_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ranging_result_averager check failed");

`endif

FILE: rtl/rra_pkg.sv
// ----------------------------------------------------------------------------
// Ranging result averager package
// Payload types, control and status bundles and fixed constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rra_pkg;

   // Distance codes.
   localparam logic [15:0] DIST_MAX     = 16'hFFFE;
   localparam logic [15:0] DIST_NONE    = 16'hFFFF;
   localparam logic [15:0] PERIOD_RESET = 16'd1500;

   // Status codes.
   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_VALID = 2'd1;
   localparam logic [1:0] STATUS_FAIL  = 2'd2;

   // Register port: address width and register indexes (byte address / 4).
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] CSR_IDX_ENABLE = 2'd0;
   localparam logic [1:0] CSR_IDX_OFFSET = 2'd1;
   localparam logic [1:0] CSR_IDX_PERIOD = 2'd2;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        responder_known;
      logic        result_valid;
      logic [31:0] session_count;
      logic [31:0] raw_distance_cm;
      logic [31:0] failure_count;
      logic        engine_busy;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] distance_cm;
      logic [15:0] mean_raw_cm;
      logic [1:0]  status;
      logic        start_measure;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic sum_step;
      logic div_start;
      logic div_step;
      logic finish;
      logic out_load;
   } rra_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic take;
      logic sum_done;
      logic div_done;
   } rra_stat_type;

endpackage

`default_nettype wire

FILE: rtl/ranging_result_averager.sv
// ----------------------------------------------------------------------------
// Ranging result averager
// Moving average of ranging distances with offset, status and scheduling.
// ----------------------------------------------------------------------------
// Usage:
// Each input item on the req_ channel is one tick: time plus a snapshot of
// the ranging engine. Every accepted item yields exactly one result item on
// the rsp_ channel, in order. Items move when valid is high and stall low.
// A tick with no new session goes from idle straight to the output state,
// where its result is loaded once the output register is free. A tick
// with a new session writes the history, sums the filled entries one per
// cycle, divides with a one-bit-per-cycle restoring divider, then applies
// the offset in the finish state and loads the result in the output state.
// The input stall drops the cycle after the load, so a new item is taken
// only once the result of the last one has been loaded. A stalled receiver
// holds the result in the output register while one further item can be
// accepted and worked on up to its own load. Reset clears the schedule,
// counters and status; the distance reads 65535 until the first session.
// Registers are written over the csr_ port: enable at 0x0, offset at 0x4,
// period at 0x8. The user must write them only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ranging_result_averager_defines.svh"

module ranging_result_averager #(
   parameter int HISTORY_DEPTH = 5
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire rra_pkg::req_payload_type         req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output rra_pkg::rsp_payload_type              rsp_data,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rra_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);
   import rra_pkg::*;

   logic         enable_ff;
   logic [10:0]  offset_ff;
   logic [15:0]  period_ff;
   logic         csr_wr;
   logic [1:0]   csr_idx;
   rra_cmd_type  cmd;
   rra_stat_type stat;
   logic         rsp_is_none;
   logic         rsp_is_valid;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         offset_ff <= '0;
         period_ff <= PERIOD_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_IDX_ENABLE: enable_ff <= csr_pwdata[0];
            CSR_IDX_OFFSET: offset_ff <= csr_pwdata[10:0];
            CSR_IDX_PERIOD: period_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (csr_idx)
         CSR_IDX_ENABLE: csr_prdata = {31'd0, enable_ff};
         CSR_IDX_OFFSET: csr_prdata = {21'd0, offset_ff};
         CSR_IDX_PERIOD: csr_prdata = {16'd0, period_ff};
         default:        csr_prdata = '0;
      endcase
   end

   rra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rra_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_data),
      .cfg_enable (enable_ff),
      .cfg_offset (offset_ff),
      .cfg_period (period_ff),
      .rsp_data   (rsp_data)
   );

   // Status of the result item on offer.
   assign rsp_is_none  = rsp_valid && (rsp_data.status == STATUS_NONE);
   assign rsp_is_valid = rsp_valid && (rsp_data.status == STATUS_VALID);

   // An accepted item keeps the block busy in the following cycle.
   `RRA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // With no session seen yet the distance reads as none.
   `RRA_ASSERT_NOW(a_none_means_no_distance, rsp_is_none, rsp_data.distance_cm == DIST_NONE)
   // A valid status always carries a clamped distance.
   `RRA_ASSERT_NOW(a_valid_has_distance, rsp_is_valid, rsp_data.distance_cm != DIST_NONE)

endmodule

`default_nettype wire

FILE: rtl/rra_ctrl.sv
// ----------------------------------------------------------------------------
// Ranging result averager controller
// Sequences accept, history sum, division, finish and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rra_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire rra_pkg::rra_stat_type stat,
   output rra_pkg::rra_cmd_type       cmd
);
   import rra_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register is free when empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.take ? ST_SUM : ST_OUT;
            end
         end
         ST_SUM: begin
            if (stat.sum_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.sum_step = 1'b1;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result valid flag follows loads and takes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rra_datapath.sv
// ----------------------------------------------------------------------------
// Ranging result averager datapath
// History memory, serial sum, restoring divider, offset clamp and schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rra_datapath #(
   parameter int HISTORY_DEPTH = 5
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rra_pkg::rra_cmd_type     cmd,
   output rra_pkg::rra_stat_type         stat,
   input  wire rra_pkg::req_payload_type req_data,
   input  wire logic                     cfg_enable,
   input  wire logic [10:0]              cfg_offset,
   input  wire logic [15:0]              cfg_period,
   output rra_pkg::rsp_payload_type      rsp_data
);
   import rra_pkg::*;

   localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W  = 16 + CNT_W;
   localparam int DCNT_W = $clog2(SUM_W + 1);

   // History store; entries are written before they are ever read.
   logic [15:0] hist_mem [HISTORY_DEPTH];
   logic [15:0] rd_data_ff;

   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [31:0]       last_sess_ff, last_sess_in;
   logic [31:0]       last_fail_ff, last_fail_in;
   logic [31:0]       next_due_ff, next_due_in;
   logic [15:0]       filt_ff, filt_in;
   logic [15:0]       mean_ff, mean_in;
   logic [1:0]        status_ff, status_in;
   logic              start_ff;
   rsp_payload_type   rsp_ff;

   logic        active;
   logic        take;
   logic        fail_chg;
   logic        start_now;
   logic [31:0] due_diff;
   logic [15:0] raw_clamped;
   logic        rd_issue;
   logic [CNT_W:0] rem_sh;
   logic [CNT_W:0] rem_diff;
   logic        rem_fits;
   logic signed [17:0] adj;

   // Decisions on the incoming item.
   assign active      = cfg_enable && req_data.responder_known;
   assign take        = active && req_data.result_valid &&
                        (req_data.session_count != last_sess_ff);
   assign fail_chg    = req_data.failure_count != last_fail_ff;
   assign due_diff    = req_data.now_ms - next_due_ff;
   assign start_now   = active && !req_data.engine_busy && !due_diff[31];
   assign raw_clamped = (req_data.raw_distance_cm > {16'd0, DIST_MAX}) ?
                        DIST_MAX : req_data.raw_distance_cm[15:0];

   // Serial sum reads one entry per cycle; data arrives in the next cycle.
   assign rd_issue = cmd.sum_step && (cnt_ff != fill_ff);

   // One restoring division step.
   assign rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_fits = rem_sh >= {1'b0, fill_ff};
   assign rem_diff = rem_sh - {1'b0, fill_ff};

   // Offset subtraction on the mean, clamped below.
   assign adj = $signed({2'b00, quo_ff[15:0]}) - $signed({{7{cfg_offset[10]}}, cfg_offset});

   assign stat.take     = take;
   assign stat.sum_done = (cnt_ff == fill_ff) && !pend_ff;
   assign stat.div_done = (dcnt_ff == DCNT_W'(SUM_W));

   always_comb begin
      wr_idx_in    = wr_idx_ff;
      fill_in      = fill_ff;
      last_sess_in = last_sess_ff;
      last_fail_in = last_fail_ff;
      next_due_in  = next_due_ff;
      status_in    = status_ff;
      if (cmd.accept && active) begin
         if (take) begin
            last_sess_in = req_data.session_count;
            wr_idx_in    = (wr_idx_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
            fill_in      = (fill_ff == CNT_W'(HISTORY_DEPTH)) ? fill_ff : fill_ff + 1'b1;
         end
         if (fail_chg) begin
            last_fail_in = req_data.failure_count;
         end
         if (take) begin
            status_in = STATUS_VALID;
         end else if (fail_chg && status_ff != STATUS_VALID) begin
            status_in = STATUS_FAIL;
         end
         if (start_now) begin
            next_due_in = req_data.now_ms + {16'd0, cfg_period};
         end
      end
   end

   // Sum sequencing.
   always_comb begin
      cnt_in  = cnt_ff;
      pend_in = pend_ff;
      sum_in  = sum_ff;
      if (cmd.accept) begin
         cnt_in  = '0;
         pend_in = 1'b0;
         sum_in  = '0;
      end else if (cmd.sum_step) begin
         pend_in = rd_issue;
         if (rd_issue) begin
            cnt_in = cnt_ff + 1'b1;
         end
         if (pend_ff) begin
            sum_in = sum_ff + {{CNT_W{1'b0}}, rd_data_ff};
         end
      end
   end

   // Divider sequencing.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         quo_in  = sum_ff;
         rem_in  = '0;
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         quo_in  = {quo_ff[SUM_W-2:0], rem_fits};
         rem_in  = rem_fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         dcnt_in = dcnt_ff + 1'b1;
      end
   end

   // Mean and filtered distance are committed at the end of an item with a new session.
   always_comb begin
      mean_in = mean_ff;
      filt_in = filt_ff;
      if (cmd.finish) begin
         mean_in = quo_ff[15:0];
         if (adj[17]) begin
            filt_in = 16'd0;
         end else if (adj[16:0] > {1'b0, DIST_MAX}) begin
            filt_in = DIST_MAX;
         end else begin
            filt_in = adj[15:0];
         end
      end
   end

   // History memory write and registered read.
   always_ff @(posedge clock) begin
      if (cmd.accept && take) begin
         hist_mem[wr_idx_ff] <= raw_clamped;
      end
      if (rd_issue) begin
         rd_data_ff <= hist_mem[cnt_ff[IDX_W-1:0]];
      end
   end

   // Working registers without reset.
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.accept) begin
         start_ff <= start_now;
      end
      if (cmd.out_load) begin
         rsp_ff.distance_cm   <= filt_ff;
         rsp_ff.mean_raw_cm   <= mean_ff;
         rsp_ff.status        <= status_ff;
         rsp_ff.start_measure <= start_ff;
      end
   end

   // Control and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         dcnt_ff      <= '0;
         last_sess_ff <= '0;
         last_fail_ff <= '0;
         next_due_ff  <= '0;
         filt_ff      <= DIST_NONE;
         mean_ff      <= '0;
         status_ff    <= STATUS_NONE;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         dcnt_ff      <= dcnt_in;
         last_sess_ff <= last_sess_in;
         last_fail_ff <= last_fail_in;
         next_due_ff  <= next_due_in;
         filt_ff      <= filt_in;
         mean_ff      <= mean_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: verif/ranging_result_averager_tb.sv
// ----------------------------------------------------------------------------
// Ranging result averager testbench
// Drives engine snapshot items into the averager and checks every result
// item against a cycle-free model of the distance ring, offset, status and
// measurement schedule. The run steps through several register settings,
// with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ranging_result_averager_tb;
   import rra_pkg::*;

   localparam int RING_DEPTH   = 5;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 7;

   // Expected results of the averager, kept in step with accepted items.
   class range_scoreboard;
      bit          enabled;
      logic [10:0] offset;
      logic [15:0] period;
      logic [15:0] ring [RING_DEPTH];
      int unsigned fill;
      int unsigned slot;
      logic [31:0] last_sessions;
      logic [31:0] last_failures;
      logic [31:0] next_due;
      logic [15:0] filtered;
      logic [15:0] mean;
      logic [1:0]  status;
      rsp_payload_type expected_reports [$];
      int mismatches;
      int ticks;
      int sessions_stored;
      int requests;
      int checked;

      function new();
         enabled = 1'b0;
         offset = '0;
         period = PERIOD_RESET;
         fill = 0;
         slot = 0;
         last_sessions = '0;
         last_failures = '0;
         next_due = '0;
         filtered = DIST_NONE;
         mean = '0;
         status = STATUS_NONE;
         foreach (ring[i]) ring[i] = '0;
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            CSR_IDX_ENABLE: enabled = value[0];
            CSR_IDX_OFFSET: offset = value[10:0];
            CSR_IDX_PERIOD: period = value[15:0];
            default: ;
         endcase
      endfunction

      // Store a new distance and refresh the mean and the filtered value.
      function void store_distance(logic [31:0] raw);
         int unsigned sum;
         int adjusted;
         int trim;
         sum = 0;
         trim = $signed(offset);
         ring[slot] = (raw > 32'(DIST_MAX)) ? DIST_MAX : raw[15:0];
         slot = (slot + 1) % RING_DEPTH;
         if (fill < RING_DEPTH) fill++;
         for (int i = 0; i < fill; i++) sum += ring[i];
         mean = 16'(sum / fill);
         adjusted = int'(mean) - trim;
         if (adjusted < 0) adjusted = 0;
         if (adjusted > int'(DIST_MAX)) adjusted = int'(DIST_MAX);
         filtered = 16'(adjusted);
         status = STATUS_VALID;
         sessions_stored++;
      endfunction

      // Work out the result of one accepted tick item.
      function void note_tick(req_payload_type t);
         rsp_payload_type r;
         logic [31:0] lag;
         r.start_measure = 1'b0;
         ticks++;
         if (enabled && t.responder_known) begin
            if (t.result_valid && t.session_count != last_sessions) begin
               last_sessions = t.session_count;
               store_distance(t.raw_distance_cm);
            end
            if (t.failure_count != last_failures) begin
               last_failures = t.failure_count;
               if (status != STATUS_VALID) status = STATUS_FAIL;
            end
            lag = t.now_ms - next_due;
            if (!t.engine_busy && !lag[31]) begin
               next_due = t.now_ms + 32'(period);
               r.start_measure = 1'b1;
               requests++;
            end
         end
         r.distance_cm = filtered;
         r.mean_raw_cm = mean;
         r.status = status;
         expected_reports.push_back(r);
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch at result %0d, %s: expected %0h, got %0h",
                     checked, what, want, got);
      endfunction

      // Compare one accepted result item with the oldest expectation.
      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_reports.size() == 0) begin
            flag("result with no tick waiting", 32'd0, 32'(got));
            return;
         end
         want = expected_reports.pop_front();
         if (got.distance_cm !== want.distance_cm)
            flag("distance_cm", want.distance_cm, got.distance_cm);
         if (got.mean_raw_cm !== want.mean_raw_cm)
            flag("mean_raw_cm", want.mean_raw_cm, got.mean_raw_cm);
         if (got.status !== want.status)
            flag("status", want.status, got.status);
         if (got.start_measure !== want.start_measure)
            flag("start_measure", want.start_measure, got.start_measure);
         checked++;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   range_scoreboard board = new();

   bit          calm = 1'b0;
   int          hold_requests = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          cycle_count = 0;
   logic [31:0] engine_now = '0;
   logic [31:0] engine_sessions = '0;
   logic [31:0] engine_failures = '0;

   ranging_result_averager dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, board.pending());
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: check accepted result items, stall at random or hold off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 27);
      end
   end

   // A register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.set_register(idx, value);
   endtask

   // Offer one tick item, at times after a random gap, and wait until it is taken.
   task automatic send_tick(input req_payload_type t);
      if (!calm && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      board.note_tick(t);
   endtask

   // Let every expected result arrive, then give the block time to settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_payload_type make_tick(
      logic [31:0] now, bit known, bit valid, logic [31:0] sessions,
      logic [31:0] raw, logic [31:0] failures, bit busy);
      req_payload_type t;
      t.now_ms = now;
      t.responder_known = known;
      t.result_valid = valid;
      t.session_count = sessions;
      t.raw_distance_cm = raw;
      t.failure_count = failures;
      t.engine_busy = busy;
      return t;
   endfunction

   // Mostly a plausible engine history, with some pure noise.
   function automatic req_payload_type random_tick();
      req_payload_type t;
      int unsigned pick;
      if ($urandom_range(0, 99) < 12) begin
         t.now_ms = $urandom;
         t.responder_known = $urandom_range(0, 1);
         t.result_valid = $urandom_range(0, 1);
         t.session_count = $urandom;
         t.raw_distance_cm = $urandom;
         t.failure_count = $urandom;
         t.engine_busy = $urandom_range(0, 1);
         return t;
      end
      if ($urandom_range(0, 99) < 4) engine_now = $urandom;
      else engine_now = engine_now + $urandom_range(0, 400);
      if ($urandom_range(0, 99) < 40) engine_sessions = engine_sessions + 1;
      if ($urandom_range(0, 99) < 8) engine_failures = engine_failures + 1;
      pick = $urandom_range(0, 99);
      t.now_ms = engine_now;
      t.responder_known = ($urandom_range(0, 99) < 95);
      t.result_valid = ($urandom_range(0, 99) < 90);
      t.session_count = engine_sessions;
      if (pick < 70) t.raw_distance_cm = $urandom_range(0, 1500);
      else if (pick < 85) t.raw_distance_cm = $urandom_range(64000, 70000);
      else t.raw_distance_cm = $urandom;
      t.failure_count = engine_failures;
      t.engine_busy = ($urandom_range(0, 99) < 25);
      return t;
   endfunction

   initial begin
      bit          phase_enable [PHASES] = '{1, 1, 1, 1, 1, 0, 1};
      logic [10:0] phase_offset [PHASES] =
         '{11'h000, 11'h419, 11'h3E7, 11'h400, 11'h3FF, 11'h005, 11'h000};
      logic [15:0] phase_period [PHASES] =
         '{16'd1500, 16'd1, 16'd65535, 16'd0, 16'd1500, 16'd300, 16'd0};
      int          phase_items [PHASES] = '{200, 220, 220, 180, 160, 30, 170};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset the block is disabled: these ticks change nothing.
      send_tick(make_tick('1, 1'b1, 1'b1, '1, '1, '1, 1'b1));
      send_tick(make_tick('0, 1'b0, 1'b0, '0, '0, '0, 1'b0));
      drain();
      csr_write(CSR_IDX_ENABLE, 32'd1);

      // Busy engine holds off the request; then the first request is made.
      send_tick(make_tick(32'd0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1));
      send_tick(make_tick(32'd10, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0));
      // A failure before any session marks the status failing.
      send_tick(make_tick(32'd20, 1'b1, 1'b0, 32'd0, 32'd0, 32'd1, 1'b0));
      // Unknown responder: a new session is ignored.
      send_tick(make_tick(32'd30, 1'b0, 1'b1, 32'd1, 32'd77, 32'd1, 1'b0));
      send_tick(make_tick(32'd40, 1'b1, 1'b1, 32'd1, 32'd100, 32'd1, 1'b0));
      // A later failure leaves a valid status alone.
      send_tick(make_tick(32'd50, 1'b1, 1'b0, 32'd1, 32'd0, 32'd2, 1'b0));
      // Same session again, and a new session without a valid result.
      send_tick(make_tick(32'd60, 1'b1, 1'b1, 32'd1, 32'd5000, 32'd2, 1'b0));
      send_tick(make_tick(32'd70, 1'b1, 1'b0, 32'd2, 32'd5000, 32'd2, 1'b0));
      // Distance clamping at and above the limit, then the ring wraps.
      send_tick(make_tick(32'd80, 1'b1, 1'b1, 32'd2, '1, 32'd2, 1'b0));
      send_tick(make_tick(32'd90, 1'b1, 1'b1, 32'd3, 32'd65534, 32'd2, 1'b0));
      send_tick(make_tick(32'd100, 1'b1, 1'b1, 32'd4, 32'd65535, 32'd2, 1'b0));
      send_tick(make_tick(32'd110, 1'b1, 1'b1, 32'd5, 32'd0, 32'd2, 1'b0));
      send_tick(make_tick(32'd120, 1'b1, 1'b1, 32'd6, 32'd300, 32'd2, 1'b0));
      // Schedule edges: exactly due, one early, half a wrap away either side.
      send_tick(make_tick(32'd1510, 1'b1, 1'b0, 32'd6, 32'd0, 32'd2, 1'b0));
      send_tick(make_tick(32'd3009, 1'b1, 1'b0, 32'd6, 32'd0, 32'd2, 1'b0));
      send_tick(make_tick(32'd3010 + 32'h8000_0000, 1'b1, 1'b0, 32'd6, 32'd0,
                          32'd2, 1'b0));
      send_tick(make_tick(32'd3010 + 32'h7FFF_FFFF, 1'b1, 1'b0, 32'd6, 32'd0,
                          32'd2, 1'b0));
      // Session counter wraps back to zero with an oversized distance.
      send_tick(make_tick(32'd3020, 1'b1, 1'b1, 32'd0, 32'd70000, 32'd2, 1'b0));
      engine_now = 32'd3020;
      engine_sessions = '0;
      engine_failures = 32'd2;

      // Random phases, one register setting each.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p == PHASES - 1) begin
            phase_offset[p] = $urandom_range(0, 2047);
            phase_period[p] = $urandom_range(0, 65535);
         end
         csr_write(CSR_IDX_ENABLE, 32'(phase_enable[p]));
         csr_write(CSR_IDX_OFFSET, 32'(phase_offset[p]));
         csr_write(CSR_IDX_PERIOD, 32'(phase_period[p]));
         calm = (p == 2);
         for (int n = 0; n < phase_items[p]; n++) begin
            if (p == 1 && n == 20) hold_requests <= hold_requests + 1;
            send_tick(random_tick());
         end
      end
      calm = 1'b0;
      drain();

      $display("Covered %0d ticks over %0d register settings: %0d distances stored,",
               board.ticks, PHASES + 1, board.sessions_stored);
      $display("%0d measurement requests, %0d results checked, %0d mismatches.",
               board.requests, board.checked, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
